>>> rtl/core/kmtf_pkg.sv
// Package for the move-to-front reply table: list geometry, command and
// status codes, the reset square order and the memory request struct.
// No dependencies.
package kmtf_pkg;

    localparam int SLOTS        = 64;
    localparam int SQ_W         = 6;
    localparam int CNT_W        = 7;
    localparam int LIST_W       = 8;
    localparam int NUM_LISTS    = 129;
    localparam int ADDR_W       = LIST_W + SQ_W;
    localparam int SQUARE_COUNT = 64;

    // List 128 is the default list; 0..127 are {side, opponent move}.
    localparam logic [LIST_W-1:0] DEFAULT_LIST = 8'd128;

    localparam logic [2:0] CMD_UPDATE   = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_INSERT   = 3'd2;
    localparam logic [2:0] CMD_READ_SIDE = 3'd3;
    localparam logic [2:0] CMD_READ_DEF = 3'd4;

    localparam logic [1:0] ST_CHANGED   = 2'd0;
    localparam logic [1:0] ST_UNCHANGED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef logic [SQ_W-1:0] t_order [SLOTS];

    localparam t_order RESET_ORDER = '{
        6'd0, 6'd56, 6'd7, 6'd63,
        6'd18, 6'd21, 6'd42, 6'd45,
        6'd26, 6'd34, 6'd29, 6'd37, 6'd19, 6'd20, 6'd43, 6'd44,
        6'd10, 6'd13, 6'd17, 6'd22, 6'd41, 6'd46, 6'd50, 6'd53,
        6'd11, 6'd12, 6'd25, 6'd30, 6'd33, 6'd38, 6'd51, 6'd52,
        6'd3, 6'd4, 6'd24, 6'd31, 6'd32, 6'd39, 6'd59, 6'd60,
        6'd2, 6'd5, 6'd16, 6'd23, 6'd40, 6'd47, 6'd58, 6'd61,
        6'd1, 6'd6, 6'd8, 6'd15, 6'd48, 6'd55, 6'd57, 6'd62,
        6'd9, 6'd14, 6'd49, 6'd54,
        6'd27, 6'd35, 6'd28, 6'd36
    };

    // Reset order with squares at or above the board size dropped; the
    // unused tail holds zero. Evaluated at elaboration only.
    function automatic t_order filtered_order(input int sq_count);
        t_order res;
        int     k;
        k = 0;
        for (int i = 0; i < SLOTS; i++) begin
            res[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (int'(RESET_ORDER[i]) < sq_count) begin
                res[6'(k)] = RESET_ORDER[i];
                k++;
            end
        end
        return res;
    endfunction

    // The requests that the sequencer gives the list memory in a cycle.
    typedef struct packed {
        logic              rd_en;
        logic [LIST_W-1:0] rd_list;
        logic [SQ_W-1:0]   rd_slot;
        logic              wr_en;
        logic [LIST_W-1:0] wr_list;
        logic [SQ_W-1:0]   wr_slot;
        logic [SQ_W-1:0]   wr_data;
        logic              set_valid;
    } t_mem_req;

endpackage

>>> rtl/core/killer_move_to_front_table_unit.sv
// Top level of the move-to-front reply table: command sequencer around the
// shared square compare and the list memory. Depends on kmtf_pkg, kmtf_list_mem.
//
// Usage: one command beat enters on i_valid/o_ready (i_cmd, i_side,
// i_opponent_move, i_square, i_rank); exactly one result beat leaves on
// o_valid/i_ready (o_status, o_read_square, o_free_count).
// The sequencer walks lists one slot at a time through the list memory,
// reading a slot and then comparing and writing it. Reads and rejected
// commands need no walk; update searches the reply list for the square and
// moves it to the front; remove and insert first search the default list,
// then edit each reply list that has been updated since reset, and the
// default list last.
// o_ready is high only while the sequencer is idle; one item at a time.
// Reset is synchronous and active low: every list reads as the
// reset square order at once, no clearing pass is run.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and runs, and waits only to deliver its result.
module killer_move_to_front_table_unit #(
    parameter int SQUARE_COUNT = kmtf_pkg::SQUARE_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_cmd,
    input  logic                       i_side,
    input  logic [kmtf_pkg::SQ_W-1:0]  i_opponent_move,
    input  logic [kmtf_pkg::SQ_W-1:0]  i_square,
    input  logic [kmtf_pkg::SQ_W-1:0]  i_rank,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic [kmtf_pkg::SQ_W-1:0]  o_read_square,
    output logic [kmtf_pkg::CNT_W-1:0] o_free_count
);

    localparam logic [kmtf_pkg::CNT_W-1:0] SQ_LIMIT = kmtf_pkg::CNT_W'(SQUARE_COUNT);
    localparam logic [kmtf_pkg::CNT_W-1:0] FULL     = kmtf_pkg::CNT_W'(kmtf_pkg::SLOTS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND_RD  = 4'd1;
    localparam logic [3:0] S_FIND_CHK = 4'd2;
    localparam logic [3:0] S_UPD_RD   = 4'd3;
    localparam logic [3:0] S_UPD_WR   = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_RM_RD    = 4'd6;
    localparam logic [3:0] S_RM_WR    = 4'd7;
    localparam logic [3:0] S_RM_TAIL  = 4'd8;
    localparam logic [3:0] S_INS_RD   = 4'd9;
    localparam logic [3:0] S_INS_WR   = 4'd10;
    localparam logic [3:0] S_INS_TAIL = 4'd11;
    localparam logic [3:0] S_RD_DATA  = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]                    r_state, n_state;
    logic [2:0]                    r_cmd, n_cmd;
    logic [kmtf_pkg::SQ_W-1:0]     r_sq, n_sq;
    logic [kmtf_pkg::LIST_W-1:0]   r_list, n_list;
    logic [kmtf_pkg::CNT_W-1:0]    r_slot, n_slot;
    logic [kmtf_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic [kmtf_pkg::SQ_W-1:0]     r_carry, n_carry;
    logic                          r_found, n_found;
    logic [kmtf_pkg::CNT_W-1:0]    r_free, n_free;
    logic [1:0]                    r_status, n_status;
    logic [kmtf_pkg::SQ_W-1:0]     r_rd, n_rd;
    logic                          r_ov, n_ov;
    logic [1:0]                    r_o_status, n_o_status;
    logic [kmtf_pkg::SQ_W-1:0]     r_o_rd, n_o_rd;
    logic [kmtf_pkg::CNT_W-1:0]    r_o_free, n_o_free;

    kmtf_pkg::t_mem_req            mem_req;
    logic [kmtf_pkg::SQ_W-1:0]     rd_data;
    logic                          list_valid;
    logic                          hit;
    logic                          last_slot;
    logic                          accept;

    kmtf_list_mem #(
        .SQUARE_COUNT(SQUARE_COUNT)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (mem_req),
        .o_rd_data   (rd_data),
        .o_list_valid(list_valid)
    );

    // The one shared compare and the end-of-list test.
    assign hit       = (rd_data == r_sq);
    assign last_slot = (kmtf_pkg::CNT_W'(r_slot + 7'd1) == r_free);
    assign accept    = i_valid && o_ready;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ov;
    assign o_status      = r_o_status;
    assign o_read_square = r_o_rd;
    assign o_free_count  = r_o_free;

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_sq     = r_sq;
        n_list   = r_list;
        n_slot   = r_slot;
        n_idx    = r_idx;
        n_carry  = r_carry;
        n_found  = r_found;
        n_free   = r_free;
        n_status = r_status;
        n_rd     = r_rd;
        n_ov     = r_ov && !i_ready;
        n_o_status = r_o_status;
        n_o_rd     = r_o_rd;
        n_o_free   = r_o_free;
        mem_req  = '0;
        mem_req.rd_list = r_list;
        mem_req.rd_slot = r_slot[5:0];
        mem_req.wr_list = r_list;
        mem_req.wr_slot = r_slot[5:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_sq     = i_square;
                    n_slot   = '0;
                    n_rd     = '0;
                    n_status = kmtf_pkg::ST_INVALID;
                    n_state  = S_DONE;
                    case (i_cmd)
                        kmtf_pkg::CMD_UPDATE: begin
                            if ({1'b0, i_opponent_move} >= SQ_LIMIT
                                || {1'b0, i_square} >= SQ_LIMIT) begin
                                n_status = kmtf_pkg::ST_INVALID;
                            end else if (r_free == '0) begin
                                n_status = kmtf_pkg::ST_NOT_FOUND;
                            end else begin
                                n_list  = {1'b0, i_side, i_opponent_move};
                                n_state = S_FIND_RD;
                            end
                        end
                        kmtf_pkg::CMD_REMOVE: begin
                            if ({1'b0, i_square} >= SQ_LIMIT) begin
                                n_status = kmtf_pkg::ST_INVALID;
                            end else if (r_free == '0) begin
                                n_status = kmtf_pkg::ST_UNCHANGED;
                            end else begin
                                n_list  = kmtf_pkg::DEFAULT_LIST;
                                n_state = S_FIND_RD;
                            end
                        end
                        kmtf_pkg::CMD_INSERT: begin
                            if ({1'b0, i_square} >= SQ_LIMIT) begin
                                n_status = kmtf_pkg::ST_INVALID;
                            end else if (r_free >= FULL) begin
                                n_status = kmtf_pkg::ST_UNCHANGED;
                            end else if (r_free == '0) begin
                                n_list  = '0;
                                n_state = S_WALK;
                            end else begin
                                n_list  = kmtf_pkg::DEFAULT_LIST;
                                n_state = S_FIND_RD;
                            end
                        end
                        kmtf_pkg::CMD_READ_SIDE: begin
                            if ({1'b0, i_opponent_move} >= SQ_LIMIT) begin
                                n_status = kmtf_pkg::ST_INVALID;
                            end else if ({1'b0, i_rank} >= r_free) begin
                                n_status = kmtf_pkg::ST_NOT_FOUND;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_list = {1'b0, i_side, i_opponent_move};
                                mem_req.rd_slot = i_rank;
                                n_state         = S_RD_DATA;
                            end
                        end
                        kmtf_pkg::CMD_READ_DEF: begin
                            if ({1'b0, i_rank} >= r_free) begin
                                n_status = kmtf_pkg::ST_NOT_FOUND;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_list = kmtf_pkg::DEFAULT_LIST;
                                mem_req.rd_slot = i_rank;
                                n_state         = S_RD_DATA;
                            end
                        end
                        default: begin
                            n_status = kmtf_pkg::ST_INVALID;
                        end
                    endcase
                end
            end

            // Search for the square, one slot per read.
            S_FIND_RD: begin
                mem_req.rd_en = 1'b1;
                n_state       = S_FIND_CHK;
            end

            S_FIND_CHK: begin
                if (hit) begin
                    if (r_cmd == kmtf_pkg::CMD_UPDATE) begin
                        if (r_slot == '0) begin
                            n_status = kmtf_pkg::ST_UNCHANGED;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = r_slot;
                            n_slot  = '0;
                            n_carry = r_sq;
                            n_state = S_UPD_RD;
                        end
                    end else if (r_cmd == kmtf_pkg::CMD_REMOVE) begin
                        n_list  = '0;
                        n_state = S_WALK;
                    end else begin
                        n_status = kmtf_pkg::ST_UNCHANGED;
                        n_state  = S_DONE;
                    end
                end else if (last_slot) begin
                    if (r_cmd == kmtf_pkg::CMD_UPDATE) begin
                        n_status = kmtf_pkg::ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else if (r_cmd == kmtf_pkg::CMD_REMOVE) begin
                        n_status = kmtf_pkg::ST_UNCHANGED;
                        n_state  = S_DONE;
                    end else begin
                        n_list  = '0;
                        n_state = S_WALK;
                    end
                end else begin
                    n_slot  = kmtf_pkg::CNT_W'(r_slot + 7'd1);
                    n_state = S_FIND_RD;
                end
            end

            // Move to front: shift slots up to the reply, copy the rest so
            // a list written for the first time becomes a full copy.
            S_UPD_RD: begin
                mem_req.rd_en = 1'b1;
                n_state       = S_UPD_WR;
            end

            S_UPD_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = (r_slot <= r_idx) ? r_carry : rd_data;
                n_carry         = rd_data;
                if (last_slot) begin
                    mem_req.set_valid = 1'b1;
                    n_status          = kmtf_pkg::ST_CHANGED;
                    n_state           = S_DONE;
                end else begin
                    n_slot  = kmtf_pkg::CNT_W'(r_slot + 7'd1);
                    n_state = S_UPD_RD;
                end
            end

            // Pick the next list to edit; unwritten reply lists follow the
            // default list and need no edit of their own.
            S_WALK: begin
                n_slot  = '0;
                n_carry = r_sq;
                n_found = 1'b0;
                if (list_valid) begin
                    if (r_cmd == kmtf_pkg::CMD_REMOVE) begin
                        n_state = S_RM_RD;
                    end else if (r_free == '0) begin
                        n_state = S_INS_TAIL;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end else begin
                    n_list = kmtf_pkg::LIST_W'(r_list + 8'd1);
                end
            end

            // Removal: after the square is seen, each slot moves down one.
            S_RM_RD: begin
                mem_req.rd_en = 1'b1;
                n_state       = S_RM_WR;
            end

            S_RM_WR: begin
                mem_req.wr_en   = r_found;
                mem_req.wr_slot = 6'(r_slot - 7'd1);
                mem_req.wr_data = rd_data;
                n_found         = r_found || hit;
                if (last_slot) begin
                    n_state = S_RM_TAIL;
                end else begin
                    n_slot  = kmtf_pkg::CNT_W'(r_slot + 7'd1);
                    n_state = S_RM_RD;
                end
            end

            S_RM_TAIL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_slot = 6'(r_free - 7'd1);
                mem_req.wr_data = '0;
                if (r_list == kmtf_pkg::DEFAULT_LIST) begin
                    n_free   = kmtf_pkg::CNT_W'(r_free - 7'd1);
                    n_status = kmtf_pkg::ST_CHANGED;
                    n_state  = S_DONE;
                end else begin
                    n_list  = kmtf_pkg::LIST_W'(r_list + 8'd1);
                    n_state = S_WALK;
                end
            end

            // Insertion: each slot moves up one, the new square goes first.
            S_INS_RD: begin
                mem_req.rd_en = 1'b1;
                n_state       = S_INS_WR;
            end

            S_INS_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = r_carry;
                n_carry         = rd_data;
                n_slot          = kmtf_pkg::CNT_W'(r_slot + 7'd1);
                n_state         = last_slot ? S_INS_TAIL : S_INS_RD;
            end

            S_INS_TAIL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_data = r_carry;
                if (r_list == kmtf_pkg::DEFAULT_LIST) begin
                    n_free   = kmtf_pkg::CNT_W'(r_free + 7'd1);
                    n_status = kmtf_pkg::ST_CHANGED;
                    n_state  = S_DONE;
                end else begin
                    n_list  = kmtf_pkg::LIST_W'(r_list + 8'd1);
                    n_state = S_WALK;
                end
            end

            S_RD_DATA: begin
                n_rd     = rd_data;
                n_status = kmtf_pkg::ST_CHANGED;
                n_state  = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_rd     = r_rd;
                    n_o_free   = r_free;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= SQ_LIMIT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_ov    <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_sq       <= n_sq;
        r_list     <= n_list;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_carry    <= n_carry;
        r_found    <= n_found;
        r_status   <= n_status;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_rd     <= n_o_rd;
        r_o_free   <= n_o_free;
    end

    // The free count never exceeds the board size.
    a_free_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= SQ_LIMIT)
        else $error("free count above board size");

    // After it accepts a command, the block is not ready in the cycle after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("ready after accepting a command");

    // The free count changes only at the end of a list walk.
    a_free_stable_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) == S_IDLE) |-> r_free == $past(r_free))
        else $error("free count changed while idle");

endmodule

>>> rtl/core/kmtf_list_mem.sv
// List store of the reply table: one memory of 129 lists x 64 slots, with a
// valid bit per reply list and per default slot. Depends on kmtf_pkg.
module kmtf_list_mem #(
    parameter int SQUARE_COUNT = kmtf_pkg::SQUARE_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kmtf_pkg::t_mem_req        i_req,
    output logic [kmtf_pkg::SQ_W-1:0] o_rd_data,
    output logic                      o_list_valid
);

    localparam kmtf_pkg::t_order ORDER     = kmtf_pkg::filtered_order(SQUARE_COUNT);
    localparam int               MEM_DEPTH = kmtf_pkg::NUM_LISTS * kmtf_pkg::SLOTS;

    logic [kmtf_pkg::SQ_W-1:0] r_mem [MEM_DEPTH];
    logic [127:0]              r_lv;
    logic [kmtf_pkg::SLOTS-1:0] r_dv;
    logic [kmtf_pkg::SQ_W-1:0] r_q;
    logic [kmtf_pkg::SQ_W-1:0] r_tab;
    logic                      r_use_tab;
    logic [kmtf_pkg::LIST_W-1:0] phys_list;
    logic                      use_tab;

    // A reply list never written mirrors the default list exactly, and a
    // default slot never written still holds its reset square.
    assign o_list_valid = i_req.rd_list[7] | r_lv[i_req.rd_list[6:0]];
    assign phys_list    = o_list_valid ? i_req.rd_list : kmtf_pkg::DEFAULT_LIST;
    assign use_tab      = (phys_list == kmtf_pkg::DEFAULT_LIST) && !r_dv[i_req.rd_slot];

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q       <= r_mem[{phys_list, i_req.rd_slot}];
            r_tab     <= ORDER[i_req.rd_slot];
            r_use_tab <= use_tab;
        end
    end

    assign o_rd_data = r_use_tab ? r_tab : r_q;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[{i_req.wr_list, i_req.wr_slot}] <= i_req.wr_data;
        end
    end

    // Valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= '0;
            r_dv <= '0;
        end else begin
            if (i_req.wr_en && i_req.wr_list[7]) begin
                r_dv[i_req.wr_slot] <= 1'b1;
            end
            if (i_req.set_valid && !i_req.wr_list[7]) begin
                r_lv[i_req.wr_list[6:0]] <= 1'b1;
            end
        end
    end

endmodule

>>> tb/killer_move_to_front_table_unit_checker.sv
// Checker for the move-to-front reply table: watches both channels, keeps its own copy
// of the lists, predicts each result beat and compares it field by field.
// Depends on kmtf_pkg.
module killer_move_to_front_table_unit_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_dut_ready,
    input  logic [2:0]                 i_cmd,
    input  logic                       i_side,
    input  logic [kmtf_pkg::SQ_W-1:0]  i_opponent_move,
    input  logic [kmtf_pkg::SQ_W-1:0]  i_square,
    input  logic [kmtf_pkg::SQ_W-1:0]  i_rank,
    input  logic                       i_dut_valid,
    input  logic                       i_ready,
    input  logic [1:0]                 i_status,
    input  logic [kmtf_pkg::SQ_W-1:0]  i_read_square,
    input  logic [kmtf_pkg::CNT_W-1:0] i_free_count,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]                 status;
        logic [kmtf_pkg::SQ_W-1:0]  read_square;
        logic [kmtf_pkg::CNT_W-1:0] free_count;
    } t_table_result;

    logic [kmtf_pkg::SQ_W-1:0]  side_lists [2][kmtf_pkg::SLOTS][kmtf_pkg::SLOTS];
    logic [kmtf_pkg::SQ_W-1:0]  base_list  [kmtf_pkg::SLOTS];
    logic [kmtf_pkg::CNT_W-1:0] free_sq;
    t_table_result              pending_results [$];
    int                         fail_count;

    assign o_fail_count  = fail_count;
    assign o_outstanding = pending_results.size();

    // Position of a square within the live part of a list; n when absent.
    function automatic int locate(ref logic [kmtf_pkg::SQ_W-1:0] lst [kmtf_pkg::SLOTS],
                                  input int n, input logic [kmtf_pkg::SQ_W-1:0] sq);
        for (int i = 0; i < n; i++) begin
            if (lst[i] == sq) return i;
        end
        return n;
    endfunction

    // Takes a square out of a list, closing the gap and clearing the freed slot.
    task automatic drop_square(ref logic [kmtf_pkg::SQ_W-1:0] lst [kmtf_pkg::SLOTS],
                               input int n, input logic [kmtf_pkg::SQ_W-1:0] sq);
        int pos;
        pos = locate(lst, n, sq);
        if (pos < n) begin
            for (int i = pos; i + 1 < n; i++) lst[i] = lst[i + 1];
            lst[n - 1] = '0;
        end
    endtask

    // Puts a square at the front of a list that has room.
    task automatic push_front(ref logic [kmtf_pkg::SQ_W-1:0] lst [kmtf_pkg::SLOTS],
                              input int n, input logic [kmtf_pkg::SQ_W-1:0] sq);
        if (n < kmtf_pkg::SLOTS) begin
            for (int i = n; i > 0; i--) lst[i] = lst[i - 1];
            lst[0] = sq;
        end
    endtask

    // Applies one command beat to the local lists and yields its result beat.
    task automatic apply_command(input logic [2:0] cmd, input logic side,
                                 input logic [kmtf_pkg::SQ_W-1:0] opp,
                                 input logic [kmtf_pkg::SQ_W-1:0] sq,
                                 input logic [kmtf_pkg::SQ_W-1:0] rank,
                                 output t_table_result res);
        int n;
        int pos;
        n = int'(free_sq);
        res.status = kmtf_pkg::ST_INVALID;
        res.read_square = '0;
        case (cmd)
            kmtf_pkg::CMD_UPDATE: begin
                if (int'(opp) < kmtf_pkg::SQUARE_COUNT && int'(sq) < kmtf_pkg::SQUARE_COUNT) begin
                    pos = locate(side_lists[side][opp], n, sq);
                    if (pos >= n) begin
                        res.status = kmtf_pkg::ST_NOT_FOUND;
                    end else if (pos == 0) begin
                        res.status = kmtf_pkg::ST_UNCHANGED;
                    end else begin
                        for (int i = pos; i >= 1; i--)
                            side_lists[side][opp][i] = side_lists[side][opp][i - 1];
                        side_lists[side][opp][0] = sq;
                        res.status = kmtf_pkg::ST_CHANGED;
                    end
                end
            end
            kmtf_pkg::CMD_REMOVE: begin
                if (int'(sq) < kmtf_pkg::SQUARE_COUNT) begin
                    if (locate(base_list, n, sq) >= n) begin
                        res.status = kmtf_pkg::ST_UNCHANGED;
                    end else begin
                        drop_square(base_list, n, sq);
                        for (int s = 0; s < 2; s++)
                            for (int m = 0; m < kmtf_pkg::SLOTS; m++)
                                drop_square(side_lists[s][m], n, sq);
                        free_sq = free_sq - 1'b1;
                        res.status = kmtf_pkg::ST_CHANGED;
                    end
                end
            end
            kmtf_pkg::CMD_INSERT: begin
                if (int'(sq) < kmtf_pkg::SQUARE_COUNT) begin
                    if (locate(base_list, n, sq) < n || n >= kmtf_pkg::SLOTS) begin
                        res.status = kmtf_pkg::ST_UNCHANGED;
                    end else begin
                        push_front(base_list, n, sq);
                        for (int s = 0; s < 2; s++)
                            for (int m = 0; m < kmtf_pkg::SLOTS; m++)
                                push_front(side_lists[s][m], n, sq);
                        free_sq = free_sq + 1'b1;
                        res.status = kmtf_pkg::ST_CHANGED;
                    end
                end
            end
            kmtf_pkg::CMD_READ_SIDE: begin
                if (int'(opp) < kmtf_pkg::SQUARE_COUNT) begin
                    if (int'(rank) >= n) begin
                        res.status = kmtf_pkg::ST_NOT_FOUND;
                    end else begin
                        res.read_square = side_lists[side][opp][rank];
                        res.status = kmtf_pkg::ST_CHANGED;
                    end
                end
            end
            kmtf_pkg::CMD_READ_DEF: begin
                if (int'(rank) >= n) begin
                    res.status = kmtf_pkg::ST_NOT_FOUND;
                end else begin
                    res.read_square = base_list[rank];
                    res.status = kmtf_pkg::ST_CHANGED;
                end
            end
            default: ;
        endcase
        res.free_count = free_sq;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    // Reset reloads the lists; afterwards every command beat is predicted and
    // every result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_table_result res;
        t_table_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < kmtf_pkg::SLOTS; i++) begin
                base_list[i] = kmtf_pkg::RESET_ORDER[i];
                for (int s = 0; s < 2; s++)
                    for (int m = 0; m < kmtf_pkg::SLOTS; m++)
                        side_lists[s][m][i] = kmtf_pkg::RESET_ORDER[i];
            end
            free_sq = kmtf_pkg::CNT_W'(kmtf_pkg::SQUARE_COUNT);
            pending_results.delete();
        end else begin
            if (i_valid && i_dut_ready) begin
                apply_command(i_cmd, i_side, i_opponent_move, i_square, i_rank, res);
                pending_results.push_back(res);
            end
            if (i_dut_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_read_square !== want.read_square)
                        report_mismatch("read_square", i_read_square, want.read_square);
                    if (i_free_count !== want.free_count)
                        report_mismatch("free_count", i_free_count, want.free_count);
                end
            end
        end
    end

endmodule

>>> tb/killer_move_to_front_table_unit_tb.sv
// Testbench top for the move-to-front reply table: clock, reset, command stimulus
// with idle phases and the verdict. Depends on kmtf_pkg, the block and its checker.
module killer_move_to_front_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 60000;

    typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} t_pace;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [2:0]                 i_cmd = '0;
    logic                       i_side = 1'b0;
    logic [kmtf_pkg::SQ_W-1:0]  i_opponent_move = '0;
    logic [kmtf_pkg::SQ_W-1:0]  i_square = '0;
    logic [kmtf_pkg::SQ_W-1:0]  i_rank = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [1:0]                 o_status;
    logic [kmtf_pkg::SQ_W-1:0]  o_read_square;
    logic [kmtf_pkg::CNT_W-1:0] o_free_count;
    int                         fail_count;
    int                         outstanding;
    t_pace                      pace = PACE_FREE;
    bit                         hold_request = 1'b0;
    int                         idle_cycles = 0;

    killer_move_to_front_table_unit dut (.*);

    killer_move_to_front_table_unit_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_dut_ready(o_ready), .i_cmd, .i_side,
        .i_opponent_move, .i_square, .i_rank, .i_dut_valid(o_valid), .i_ready,
        .i_status(o_status), .i_read_square(o_read_square), .i_free_count(o_free_count),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls by phase, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if (pace == PACE_RECEIVER || pace == PACE_BOTH)
                i_ready <= ($urandom_range(0, 99) >= 57);
            else
                i_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("killer_move_to_front_table_unit_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one command beat, with an optional random gap before it.
    task automatic send_command(input logic [2:0] cmd, input logic side,
                                input logic [kmtf_pkg::SQ_W-1:0] opp,
                                input logic [kmtf_pkg::SQ_W-1:0] sq,
                                input logic [kmtf_pkg::SQ_W-1:0] rank);
        if (pace == PACE_SENDER || pace == PACE_BOTH) begin
            if ($urandom_range(0, 99) < 57) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while ($urandom_range(0, 99) < 57) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_side <= side;
        i_opponent_move <= opp;
        i_square <= sq;
        i_rank <= rank;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Random command mix; updates mostly hit a few lists to keep walks short.
    task automatic send_random;
        int                        pick;
        logic [2:0]                cmd;
        logic [kmtf_pkg::SQ_W-1:0] opp;
        pick = $urandom_range(0, 99);
        if (pick < 55)      cmd = kmtf_pkg::CMD_UPDATE;
        else if (pick < 62) cmd = kmtf_pkg::CMD_REMOVE;
        else if (pick < 69) cmd = kmtf_pkg::CMD_INSERT;
        else if (pick < 82) cmd = kmtf_pkg::CMD_READ_SIDE;
        else if (pick < 94) cmd = kmtf_pkg::CMD_READ_DEF;
        else                cmd = 3'($urandom_range(5, 7));
        opp = ($urandom_range(0, 9) < 8) ? kmtf_pkg::SQ_W'($urandom_range(0, 7))
                                          : kmtf_pkg::SQ_W'($urandom_range(0, 63));
        send_command(cmd, 1'($urandom_range(0, 1)), opp,
                     kmtf_pkg::SQ_W'($urandom_range(0, 63)),
                     kmtf_pkg::SQ_W'($urandom_range(0, 63)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: front reply, moved reply, full-table insert, removal and re-insert,
        // reads at both ends and past the free count, unknown commands.
        send_command(kmtf_pkg::CMD_UPDATE, 1'b0, 6'd0, 6'd0, 6'd0);
        send_command(kmtf_pkg::CMD_UPDATE, 1'b1, 6'd63, 6'd36, 6'd63);
        send_command(kmtf_pkg::CMD_UPDATE, 1'b1, 6'd63, 6'd36, 6'd0);
        send_command(kmtf_pkg::CMD_READ_SIDE, 1'b1, 6'd63, 6'd0, 6'd0);
        send_command(kmtf_pkg::CMD_READ_SIDE, 1'b1, 6'd63, 6'd0, 6'd63);
        send_command(kmtf_pkg::CMD_READ_DEF, 1'b0, 6'd0, 6'd0, 6'd63);
        send_command(kmtf_pkg::CMD_INSERT, 1'b0, 6'd0, 6'd63, 6'd0);
        send_command(kmtf_pkg::CMD_REMOVE, 1'b0, 6'd0, 6'd36, 6'd0);
        send_command(kmtf_pkg::CMD_REMOVE, 1'b0, 6'd0, 6'd36, 6'd0);
        send_command(kmtf_pkg::CMD_UPDATE, 1'b1, 6'd63, 6'd36, 6'd0);
        send_command(kmtf_pkg::CMD_READ_DEF, 1'b0, 6'd0, 6'd0, 6'd63);
        send_command(kmtf_pkg::CMD_READ_SIDE, 1'b0, 6'd21, 6'd0, 6'd62);
        send_command(kmtf_pkg::CMD_REMOVE, 1'b1, 6'd63, 6'd0, 6'd63);
        send_command(kmtf_pkg::CMD_READ_SIDE, 1'b0, 6'd0, 6'd0, 6'd0);
        send_command(kmtf_pkg::CMD_INSERT, 1'b0, 6'd0, 6'd36, 6'd0);
        send_command(kmtf_pkg::CMD_INSERT, 1'b0, 6'd0, 6'd0, 6'd0);
        send_command(kmtf_pkg::CMD_INSERT, 1'b0, 6'd0, 6'd0, 6'd0);
        send_command(kmtf_pkg::CMD_READ_SIDE, 1'b1, 6'd63, 6'd0, 6'd1);
        send_command(3'd5, 1'b1, 6'd63, 6'd63, 6'd63);
        send_command(3'd6, 1'b0, 6'd0, 6'd0, 6'd0);
        send_command(3'd7, 1'b1, 6'd42, 6'd21, 6'd42);

        // Random phases; the first one opens with a long receiver hold-off.
        hold_request = 1'b1;
        for (int p = 0; p < 4; p++) begin
            pace = t_pace'(p);
            for (int n = 0; n < 160; n++) send_random();
        end
        pace = PACE_FREE;
        i_valid <= 1'b0;

        // Let the checker log the last beat, drain, then a short quiet spell.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("killer_move_to_front_table_unit_tb: PASS");
        else
            $display("killer_move_to_front_table_unit_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/kmtf_pkg.sv
rtl/core/kmtf_list_mem.sv
rtl/core/killer_move_to_front_table_unit.sv
tb/killer_move_to_front_table_unit_checker.sv
tb/killer_move_to_front_table_unit_tb.sv
